/* sv/spm_pkg.sv */
// shared constants and types for the stack p-code machine
package spm_pkg;

  localparam int StackDepth   = 4096;
  localparam int SymbolDepth  = 128;
  localparam int ProgramDepth = 512;
  localparam int SaW          = $clog2(StackDepth);
  localparam int SymW         = $clog2(SymbolDepth);
  localparam int TopW         = SaW + 1;

  localparam logic [3:0] OP_LIT = 4'd0;
  localparam logic [3:0] OP_OPR = 4'd1;
  localparam logic [3:0] OP_LOD = 4'd2;
  localparam logic [3:0] OP_STO = 4'd3;
  localparam logic [3:0] OP_CMP = 4'd4;
  localparam logic [3:0] OP_INI = 4'd5;
  localparam logic [3:0] OP_JMP = 4'd6;
  localparam logic [3:0] OP_JPC = 4'd7;
  localparam logic [3:0] OP_GETARR = 4'd8;
  localparam logic [3:0] OP_CREATE = 4'd9;
  localparam logic [3:0] OP_STOREARR = 4'd10;
  localparam logic [3:0] OP_LOADARR = 4'd11;

  localparam logic [10:0] FN_WRITE = 11'd1;
  localparam logic [10:0] FN_READ  = 11'd2;
  localparam logic [10:0] FN_LT = 11'd3;
  localparam logic [10:0] FN_LE = 11'd4;
  localparam logic [10:0] FN_GT = 11'd5;
  localparam logic [10:0] FN_GE = 11'd6;
  localparam logic [10:0] FN_NE = 11'd7;
  localparam logic [10:0] FN_EQ = 11'd8;
  localparam logic [10:0] FN_ADD = 11'd9;
  localparam logic [10:0] FN_SUB = 11'd10;
  localparam logic [10:0] FN_MUL = 11'd11;
  localparam logic [10:0] FN_DIV = 11'd12;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_OVER  = 3'd1;
  localparam logic [2:0] ERR_UNDER = 3'd2;
  localparam logic [2:0] ERR_DIV   = 3'd3;
  localparam logic [2:0] ERR_ADDR  = 3'd4;

  // shared alu operations
  typedef enum logic [1:0] {ALU_MUL, ALU_DIV} alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

endpackage

/* sv/stack_pcode_machine.sv */
// stack p-code machine top level: sequencer, stack memory, symbol table
//  channel | signals                                   | dir
//  cfg     | cfg_valid cfg_ready cfg_data              | in
//  in      | in_valid in_ready req_type .. entry_dim2  | in
//  out     | out_valid out_ready next_pc .. error_code | out
// after reset a clearing pass zeroes the stack memory and the symbol kinds and
//   dimensions; no item is taken while it runs
// simple instructions step through S_RD1, S_RD2, S_RD3 and S_EXEC, load_arr adds
//   S_DEREF and S_DEREF2, bound by the single stack memory port
// mul and div also pass S_ALU and S_ALUW, waiting on the shared bit-serial unit
// one item at a time; in_ready is low until the result has been taken
module stack_pcode_machine (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         req_type,
  input  logic [3:0]   opcode,
  input  logic [10:0]  operand,
  input  logic signed [31:0] read_value,
  input  logic [1:0]   entry_kind,
  input  logic [11:0]  entry_dim1,
  input  logic [11:0]  entry_dim2,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [10:0]  next_pc,
  output logic         halted,
  output logic         write_valid,
  output logic signed [31:0] write_value,
  output logic [12:0]  stack_depth,
  output logic [2:0]   error_code
);

  localparam int SaW  = spm_pkg::SaW;
  localparam int TopW = spm_pkg::TopW;
  localparam int SymW = spm_pkg::SymW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_RD3, S_EXEC, S_ALU, S_ALUW, S_DEREF, S_DEREF2, S_OUT
  } state_t;

  state_t state;
  logic [8:0]  program_length;
  logic [TopW-1:0] top;
  logic [10:0] pc;
  logic [TopW-1:0] clr_cnt;

  // latched request
  logic        r_req;
  logic [3:0]  r_op;
  logic [10:0] r_arg;
  logic [31:0] r_rd;
  logic [1:0]  r_kind;
  logic [11:0] r_d1;
  logic [11:0] r_d2;

  // stack memory, one port
  logic [31:0] mem [spm_pkg::StackDepth];
  logic        mem_we;
  logic [SaW-1:0] mem_addr;
  logic [31:0] mem_wdata;
  logic [31:0] mem_q;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_q <= mem[mem_addr];
  end

  // symbol table memories
  logic [TopW-1:0] sym_addr [spm_pkg::SymbolDepth];
  logic [1:0]  sym_kind [spm_pkg::SymbolDepth];
  logic [11:0] sym_d1 [spm_pkg::SymbolDepth];
  logic [11:0] sym_d2 [spm_pkg::SymbolDepth];
  logic [spm_pkg::SymbolDepth-1:0] sym_vld;
  logic [TopW-1:0] sa_q;
  logic        sa_set;
  logic [1:0]  kind_q;
  logic [11:0] d1_q;
  logic [11:0] d2_q;
  logic        sym_we_addr;
  logic        sym_we_entry;
  logic [TopW-1:0] sym_wdata;

  // kinds and dimensions are zeroed during the clearing pass
  always_ff @(posedge clk) begin
    if (sym_we_addr) sym_addr[r_arg[SymW-1:0]] <= sym_wdata;
    if (state == S_CLEAR) begin
      sym_kind[clr_cnt[SymW-1:0]] <= '0;
      sym_d1[clr_cnt[SymW-1:0]]   <= '0;
      sym_d2[clr_cnt[SymW-1:0]]   <= '0;
    end else if (sym_we_entry) begin
      sym_kind[r_arg[SymW-1:0]] <= r_kind;
      sym_d1[r_arg[SymW-1:0]]   <= r_d1;
      sym_d2[r_arg[SymW-1:0]]   <= r_d2;
    end
    sa_q   <= sym_addr[r_arg[SymW-1:0]];
    kind_q <= sym_kind[r_arg[SymW-1:0]];
    d1_q   <= sym_d1[r_arg[SymW-1:0]];
    d2_q   <= sym_d2[r_arg[SymW-1:0]];
  end

  // shared alu
  spm_pkg::alu_ctl_t alu_ctl;
  logic [31:0] alu_a, alu_b, alu_res;
  logic        alu_done;

  spm_alu u_alu (
    .clk(clk), .rst(rst), .ctl(alu_ctl), .a(alu_a), .b(alu_b),
    .done(alu_done), .result(alu_res)
  );

  // operand registers
  logic [31:0] x, y;
  logic        sym_ok;
  logic        sa_ok;
  logic        sv_ok;
  logic [SaW-1:0] t1, t2;
  logic [23:0] size;

  assign sym_ok = (r_arg < 11'(spm_pkg::SymbolDepth));
  assign sa_ok  = sa_set && (sa_q < TopW'(spm_pkg::StackDepth));
  assign t1 = SaW'(top - TopW'(1));
  assign t2 = SaW'(top - TopW'(2));
  assign size = (kind_q == 2'd2) ? (24'(d1_q) * 24'(d2_q)) : 24'(d1_q);

  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign in_ready  = (state == S_IDLE);
  assign alu_a = x;
  assign alu_b = y;

  function automatic logic [31:0] cmp_fn(input logic [10:0] fn, input logic [31:0] a,
                                         input logic [31:0] b);
    logic lt, gt;
    lt = $signed(a) < $signed(b);
    gt = $signed(b) < $signed(a);
    case (fn)
      spm_pkg::FN_LT:  cmp_fn = {31'd0, lt};
      spm_pkg::FN_LE:  cmp_fn = {31'd0, !gt};
      spm_pkg::FN_GT:  cmp_fn = {31'd0, gt};
      spm_pkg::FN_GE:  cmp_fn = {31'd0, !lt};
      spm_pkg::FN_NE:  cmp_fn = {31'd0, a != b};
      spm_pkg::FN_EQ:  cmp_fn = {31'd0, a == b};
      spm_pkg::FN_ADD: cmp_fn = a + b;
      default:         cmp_fn = a - b;
    endcase
  endfunction

  // memory and table port control
  always_comb begin
    mem_we = 1'b0;
    mem_addr = t1;
    mem_wdata = x;
    sym_we_addr = 1'b0;
    sym_we_entry = 1'b0;
    sym_wdata = top;
    alu_ctl = '{start: 1'b0, op: spm_pkg::ALU_MUL};
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_cnt[SaW-1:0];
        mem_wdata = '0;
      end
      S_RD1: mem_addr = t1;
      S_RD2: mem_addr = t2;
      S_RD3: mem_addr = sa_q[SaW-1:0];
      S_DEREF: mem_addr = x[SaW-1:0];
      S_ALU: begin
        alu_ctl.start = 1'b1;
        alu_ctl.op = (r_arg == spm_pkg::FN_DIV) ? spm_pkg::ALU_DIV : spm_pkg::ALU_MUL;
      end
      S_ALUW: begin
        // top already dropped by one, so the lower operand slot is top - 1
        mem_addr = t1;
        mem_wdata = alu_res;
        mem_we = alu_done;
      end
      S_DEREF2: begin
        mem_addr = t1;
        mem_wdata = mem_q;
        mem_we = 1'b1;
      end
      S_EXEC: begin
        if (r_req) begin
          sym_we_entry = sym_ok;
        end else begin
          case (r_op)
            spm_pkg::OP_LIT: begin
              mem_addr = top[SaW-1:0];
              mem_wdata = {21'd0, r_arg};
              mem_we = !top[SaW];
            end
            spm_pkg::OP_OPR: begin
              if (r_arg == spm_pkg::FN_READ) begin
                mem_addr = top[SaW-1:0];
                mem_wdata = r_rd;
                mem_we = !top[SaW];
              end else if (r_arg >= spm_pkg::FN_LT && r_arg <= spm_pkg::FN_ADD + 11'd1) begin
                mem_addr = t2;
                mem_wdata = cmp_fn(r_arg, y, x);
                mem_we = top >= TopW'(2);
              end
            end
            spm_pkg::OP_LOD: begin
              mem_addr = top[SaW-1:0];
              mem_wdata = mem_q;
              mem_we = sym_ok && sa_ok && !top[SaW];
            end
            spm_pkg::OP_STO: begin
              mem_addr = sa_q[SaW-1:0];
              mem_wdata = x;
              mem_we = sym_ok && top != '0 && sa_ok;
            end
            spm_pkg::OP_INI: begin
              sym_we_addr = sym_ok && !top[SaW];
            end
            spm_pkg::OP_GETARR: begin
              mem_addr = top[SaW-1:0];
              mem_wdata = 32'(sa_q);
              mem_we = sym_ok && sa_ok && !top[SaW];
            end
            spm_pkg::OP_CREATE: begin
              sym_we_addr = sym_ok && (kind_q == 2'd1 || kind_q == 2'd2) &&
                            (25'(size) <= 25'(TopW'(spm_pkg::StackDepth) - top));
            end
            spm_pkg::OP_STOREARR: begin
              mem_addr = x[SaW-1:0];
              mem_wdata = y;
              mem_we = top >= TopW'(2) && x < 32'(spm_pkg::StackDepth);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      top <= '0;
      pc <= '0;
      program_length <= '0;
      out_valid <= 1'b0;
      sym_vld <= '0;
    end else begin
      if (cfg_valid && cfg_ready) program_length <= cfg_data;
      if (sym_we_addr || sym_we_entry) sym_vld[r_arg[SymW-1:0]] <= sym_we_addr;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + TopW'(1);
          if (clr_cnt == TopW'(spm_pkg::StackDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            r_req <= req_type; r_op <= opcode; r_arg <= operand; r_rd <= read_value;
            r_kind <= entry_kind; r_d1 <= entry_dim1; r_d2 <= entry_dim2;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          sa_set <= sym_ok && sym_vld[r_arg[SymW-1:0]];
          state <= S_RD2;
        end
        S_RD2: begin
          x <= mem_q;
          state <= S_RD3;
        end
        S_RD3: begin
          y <= mem_q;
          state <= S_EXEC;
        end
        S_EXEC: begin
          // y: stack[t-2] or stack[sa]; x: stack[t-1]
          logic [2:0] err;
          logic [10:0] npc;
          logic [TopW-1:0] nt;
          logic wv;
          err = spm_pkg::ERR_OK;
          npc = pc + 11'd1;
          nt = top;
          wv = 1'b0;
          if (r_op == spm_pkg::OP_LOD) y <= mem_q;
          if (r_req) begin
            if (!sym_ok) err = spm_pkg::ERR_ADDR;
            npc = pc;
          end else begin
            case (r_op)
              spm_pkg::OP_LIT:
                if (top[SaW]) err = spm_pkg::ERR_OVER; else nt = top + TopW'(1);
              spm_pkg::OP_OPR: begin
                if (r_arg == spm_pkg::FN_WRITE) begin
                  if (top == '0) err = spm_pkg::ERR_UNDER;
                  else begin nt = top - TopW'(1); wv = 1'b1; end
                end else if (r_arg == spm_pkg::FN_READ) begin
                  if (top[SaW]) err = spm_pkg::ERR_OVER; else nt = top + TopW'(1);
                end else if (r_arg >= spm_pkg::FN_LT && r_arg <= spm_pkg::FN_DIV) begin
                  if (top < TopW'(2)) err = spm_pkg::ERR_UNDER;
                  else if (r_arg == spm_pkg::FN_DIV && x == '0) err = spm_pkg::ERR_DIV;
                  else nt = top - TopW'(1);
                end
              end
              spm_pkg::OP_LOD, spm_pkg::OP_GETARR:
                if (!sym_ok || !sa_ok) err = spm_pkg::ERR_ADDR;
                else if (top[SaW]) err = spm_pkg::ERR_OVER;
                else nt = top + TopW'(1);
              spm_pkg::OP_STO:
                if (!sym_ok) err = spm_pkg::ERR_ADDR;
                else if (top == '0) err = spm_pkg::ERR_UNDER;
                else if (!sa_ok) err = spm_pkg::ERR_ADDR;
                else nt = top - TopW'(1);
              spm_pkg::OP_INI:
                if (!sym_ok) err = spm_pkg::ERR_ADDR;
                else if (top[SaW]) err = spm_pkg::ERR_OVER;
                else nt = top + TopW'(1);
              spm_pkg::OP_JMP:
                if (r_arg > 11'(spm_pkg::ProgramDepth)) err = spm_pkg::ERR_ADDR;
                else npc = r_arg;
              spm_pkg::OP_JPC:
                if (top == '0) err = spm_pkg::ERR_UNDER;
                else if (r_arg > 11'(spm_pkg::ProgramDepth)) err = spm_pkg::ERR_ADDR;
                else begin
                  nt = top - TopW'(1);
                  if (x == '0) npc = r_arg;
                end
              spm_pkg::OP_CREATE:
                if (!sym_ok) err = spm_pkg::ERR_ADDR;
                else if (kind_q == 2'd1 || kind_q == 2'd2) begin
                  if (25'(size) > 25'(TopW'(spm_pkg::StackDepth) - top))
                    err = spm_pkg::ERR_OVER;
                  else nt = top + TopW'(size);
                end
              spm_pkg::OP_STOREARR:
                if (top < TopW'(2)) err = spm_pkg::ERR_UNDER;
                else if (x >= 32'(spm_pkg::StackDepth)) err = spm_pkg::ERR_ADDR;
                else nt = top - TopW'(2);
              spm_pkg::OP_LOADARR:
                if (top == '0) err = spm_pkg::ERR_UNDER;
                else if (x >= 32'(spm_pkg::StackDepth)) err = spm_pkg::ERR_ADDR;
                default: ;
            endcase
            pc <= npc;
            top <= nt;
          end
          next_pc <= npc;
          halted <= npc > {2'd0, program_length};
          write_valid <= wv;
          write_value <= wv ? x : 32'd0;
          stack_depth <= 13'(nt);
          error_code <= err;
          if (!r_req && r_op == spm_pkg::OP_OPR && err == spm_pkg::ERR_OK &&
              (r_arg == spm_pkg::FN_MUL || r_arg == spm_pkg::FN_DIV)) begin
            x <= y; y <= x; state <= S_ALU;
          end else if (!r_req && r_op == spm_pkg::OP_LOADARR && err == spm_pkg::ERR_OK) begin
            state <= S_DEREF;
          end else begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_ALU: state <= S_ALUW;
        S_ALUW: if (alu_done) begin out_valid <= 1'b1; state <= S_OUT; end
        S_DEREF: state <= S_DEREF2;
        S_DEREF2: begin out_valid <= 1'b1; state <= S_OUT; end
        S_OUT: if (out_ready) begin out_valid <= 1'b0; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken while result pending");
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top <= TopW'(spm_pkg::StackDepth)) else $error("stack top out of range");
  a_write_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> error_code == spm_pkg::ERR_OK)
    else $error("write with error");
`endif

endmodule

/* sv/spm_alu.sv */
// iterative shift-add multiplier and restoring divider, one bit per cycle
module spm_alu (
  input  logic                clk,
  input  logic                rst,
  input  spm_pkg::alu_ctl_t   ctl,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output logic                done,
  output logic [31:0]         result
);

  logic [31:0] acc;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  spm_pkg::alu_op_t op;
  logic [32:0] trial;

  assign trial = {rem[31:0], opa[31]} - {1'b0, opb};

  // one step per cycle; the divide sign fix is applied combinationally on the result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        op   <= ctl.op;
        acc  <= '0;
        rem  <= '0;
        if (ctl.op == spm_pkg::ALU_DIV) begin
          opa <= a[31] ? 32'd0 - a : a;
          opb <= b[31] ? 32'd0 - b : b;
          neg <= a[31] ^ b[31];
        end else begin
          opa <= a;
          opb <= b;
          neg <= 1'b0;
        end
      end else if (busy) begin
        if (op == spm_pkg::ALU_MUL) begin
          if (opb[0]) acc <= acc + opa;
          opa <= opa << 1;
          opb <= opb >> 1;
        end else begin
          if (!trial[32]) begin
            rem <= trial[31:0];
            opa <= {opa[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], opa[31]};
            opa <= {opa[30:0], 1'b0};
          end
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (op == spm_pkg::ALU_MUL) result = acc;
    else result = neg ? 32'd0 - opa : opa;
  end

endmodule
